[sv/swq_pkg.sv]
// shared types and constants for the semaphore table with wait queues
`default_nettype none

package swq_pkg;

   localparam int SLOT_BITS      = 4;
   localparam int COUNT_BITS     = 16;
   localparam int REQUESTER_BITS = 8;
   localparam int STATUS_BITS    = 3;

   localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = 16'sh8000;
   localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = 16'sh7fff;

   typedef enum logic [1:0] {
      KIND_CREATE = 2'd0,
      KIND_DOWN   = 2'd1,
      KIND_UP     = 2'd2,
      KIND_CLOSE  = 2'd3
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK         = 3'd0,
      STATUS_INVALID    = 3'd1,
      STATUS_QUEUE_FULL = 3'd2,
      STATUS_TABLE_FULL = 3'd3,
      STATUS_WAITERS    = 3'd4
   } status_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;   // input transfer: register request, read slot entry
      logic exec;      // update slot entry and wait queue
      logic load;      // move finished result into output register
   } cmd_type;

endpackage

`default_nettype wire

[sv/swq_ctrl.sv]
// controller state machine: sequences capture, execute and result load
`default_nettype none

module swq_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output swq_pkg::cmd_type     cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      req_stall   = (state_ff == S_EXEC) || ((state_ff == S_FINISH) && !out_free);
      cmd.capture = req_valid && !req_stall;
      cmd.exec    = (state_ff == S_EXEC);
      cmd.load    = (state_ff == S_FINISH) && out_free;

      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.capture) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) state_in = cmd.capture ? S_EXEC : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[sv/swq_datapath.sv]
// datapath: slot table, per-slot wait queues and result registers
`default_nettype none

module swq_datapath #(
   parameter int NUM_SLOTS   = 16,
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire swq_pkg::cmd_type                        cmd,
   input  wire logic [1:0]                              req_kind,
   input  wire logic [swq_pkg::SLOT_BITS-1:0]           req_slot,
   input  wire logic signed [swq_pkg::COUNT_BITS-1:0]   req_initial_count,
   input  wire logic [swq_pkg::REQUESTER_BITS-1:0]      req_requester,
   output logic [swq_pkg::STATUS_BITS-1:0]              rsp_status,
   output logic [swq_pkg::SLOT_BITS-1:0]                rsp_slot_given,
   output logic                                         rsp_must_wait,
   output logic                                         rsp_wake_valid,
   output logic [swq_pkg::REQUESTER_BITS-1:0]           rsp_wake_requester
);

   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int CW = swq_pkg::COUNT_BITS;
   localparam int RW = swq_pkg::REQUESTER_BITS;
   localparam int EW = CW + QW + FW;
   localparam int WD = NUM_SLOTS * QUEUE_DEPTH;
   localparam int WA = $clog2(WD);

   localparam logic [8:0]    NUM_SLOTS_W = 9'(NUM_SLOTS);
   localparam logic [FW-1:0] DEPTH_F     = FW'(QUEUE_DEPTH);
   localparam logic [QW:0]   DEPTH_Q     = (QW+1)'(QUEUE_DEPTH);
   localparam logic [QW-1:0] HEAD_LAST   = QW'(QUEUE_DEPTH - 1);
   localparam logic [WA-1:0] DEPTH_A     = WA'(QUEUE_DEPTH);

   // slot entry: count, queue head, queue fill
   logic [EW-1:0]   slot_mem [NUM_SLOTS];
   logic [RW-1:0]   waiter_mem [WD];
   logic [NUM_SLOTS-1:0] in_use_ff, in_use_in;

   logic [EW-1:0]   slot_rd_ff;
   logic [RW-1:0]   waiter_rd_ff;

   // registered request
   swq_pkg::kind_type             kind_ff;
   logic [swq_pkg::SLOT_BITS-1:0] slot_ff;
   logic signed [CW-1:0]          init_ff;
   logic [RW-1:0]                 requester_ff;
   logic                          in_range_ff;
   logic [SW-1:0]                 idx_ff;

   // pending result and output registers
   logic [swq_pkg::STATUS_BITS-1:0] pend_status_ff, pend_status_in;
   logic [swq_pkg::SLOT_BITS-1:0]   pend_given_ff, pend_given_in;
   logic                            pend_wait_ff, pend_wait_in;
   logic                            pend_wake_ff, pend_wake_in;
   logic [swq_pkg::STATUS_BITS-1:0] rsp_status_ff;
   logic [swq_pkg::SLOT_BITS-1:0]   rsp_given_ff;
   logic                            rsp_wait_ff;
   logic                            rsp_wake_ff;
   logic [RW-1:0]                   rsp_wake_req_ff;

   // capture-side index
   logic [8:0]    req_slot_wide;
   logic          req_in_range;
   logic [SW-1:0] req_idx;

   assign req_slot_wide = 9'(req_slot);
   assign req_in_range  = req_slot_wide < NUM_SLOTS_W;
   assign req_idx       = req_in_range ? req_slot_wide[SW-1:0] : '0;

   // execute-side decode
   logic signed [CW-1:0] cnt;
   logic [QW-1:0]        head;
   logic [FW-1:0]        fill;
   logic [QW:0]          tail_sum;
   logic [QW-1:0]        tail;
   logic [QW-1:0]        head_next;
   logic signed [CW-1:0] cnt_up;
   logic                 slot_ok;
   logic                 free_found;
   logic [SW-1:0]        free_idx;
   logic [WA-1:0]        base_addr;

   logic                 slot_we;
   logic [SW-1:0]        slot_wa;
   logic [EW-1:0]        slot_wd;
   logic                 waiter_we;
   logic [WA-1:0]        waiter_wa;
   logic                 waiter_re;
   logic [WA-1:0]        waiter_ra;

   assign cnt  = slot_rd_ff[EW-1 -: CW];
   assign head = slot_rd_ff[FW +: QW];
   assign fill = slot_rd_ff[FW-1:0];

   assign tail_sum  = (QW+1)'(head) + (QW+1)'(fill);
   assign tail      = (tail_sum >= DEPTH_Q) ? QW'(tail_sum - DEPTH_Q) : tail_sum[QW-1:0];
   assign head_next = (head == HEAD_LAST) ? '0 : head + QW'(1);
   assign cnt_up    = (cnt != swq_pkg::COUNT_MAX) ? cnt + CW'(1) : cnt;
   assign slot_ok   = in_range_ff && in_use_ff[idx_ff];
   assign base_addr = WA'(idx_ff) * DEPTH_A;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
         if (!in_use_ff[s]) begin
            free_found = 1'b1;
            free_idx   = SW'(s);
         end
      end
   end

   always_comb begin
      pend_status_in = pend_status_ff;
      pend_given_in  = pend_given_ff;
      pend_wait_in   = pend_wait_ff;
      pend_wake_in   = pend_wake_ff;
      in_use_in      = in_use_ff;
      slot_we        = 1'b0;
      slot_wa        = idx_ff;
      slot_wd        = slot_rd_ff;
      waiter_we      = 1'b0;
      waiter_wa      = base_addr + WA'(tail);
      waiter_re      = 1'b0;
      waiter_ra      = base_addr + WA'(head);

      if (cmd.exec) begin
         pend_status_in = swq_pkg::STATUS_OK;
         pend_given_in  = slot_ff;
         pend_wait_in   = 1'b0;
         pend_wake_in   = 1'b0;
         if (kind_ff == swq_pkg::KIND_CREATE) begin
            if (free_found) begin
               in_use_in[free_idx] = 1'b1;
               slot_we       = 1'b1;
               slot_wa       = free_idx;
               slot_wd       = {init_ff, {QW{1'b0}}, {FW{1'b0}}};
               pend_given_in = swq_pkg::SLOT_BITS'(free_idx);
            end else begin
               pend_status_in = swq_pkg::STATUS_TABLE_FULL;
               pend_given_in  = '0;
            end
         end else if (!slot_ok) begin
            pend_status_in = swq_pkg::STATUS_INVALID;
         end else begin
            case (kind_ff)
               swq_pkg::KIND_DOWN: begin
                  if (cnt == swq_pkg::COUNT_MIN) begin
                     pend_status_in = swq_pkg::STATUS_QUEUE_FULL;
                  end else if (cnt[CW-1] || cnt == '0) begin
                     if (fill == DEPTH_F) begin
                        pend_status_in = swq_pkg::STATUS_QUEUE_FULL;
                     end else begin
                        waiter_we    = 1'b1;
                        slot_we      = 1'b1;
                        slot_wd      = {cnt - CW'(1), head, fill + FW'(1)};
                        pend_wait_in = 1'b1;
                     end
                  end else begin
                     slot_we = 1'b1;
                     slot_wd = {cnt - CW'(1), head, fill};
                  end
               end
               swq_pkg::KIND_UP: begin
                  slot_we = 1'b1;
                  if ((cnt_up[CW-1] || cnt_up == '0) && fill != '0) begin
                     waiter_re    = 1'b1;
                     slot_wd      = {cnt_up, head_next, fill - FW'(1)};
                     pend_wake_in = 1'b1;
                  end else begin
                     slot_wd = {cnt_up, head, fill};
                  end
               end
               swq_pkg::KIND_CLOSE: begin
                  if (fill != '0) pend_status_in = swq_pkg::STATUS_WAITERS;
                  else in_use_in[idx_ff] = 1'b0;
               end
               default: begin
                  pend_status_in = swq_pkg::STATUS_INVALID;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
      end else begin
         in_use_ff <= in_use_in;
      end
   end

   // slot table memory
   always_ff @(posedge clock) begin
      if (cmd.capture) slot_rd_ff <= slot_mem[req_idx];
      if (slot_we) slot_mem[slot_wa] <= slot_wd;
   end

   // waiter memory
   always_ff @(posedge clock) begin
      if (waiter_re) waiter_rd_ff <= waiter_mem[waiter_ra];
      if (waiter_we) waiter_mem[waiter_wa] <= requester_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff      <= swq_pkg::kind_type'(req_kind);
         slot_ff      <= req_slot;
         init_ff      <= req_initial_count;
         requester_ff <= req_requester;
         in_range_ff  <= req_in_range;
         idx_ff       <= req_idx;
      end
      pend_status_ff <= pend_status_in;
      pend_given_ff  <= pend_given_in;
      pend_wait_ff   <= pend_wait_in;
      pend_wake_ff   <= pend_wake_in;
      if (cmd.load) begin
         rsp_status_ff   <= pend_status_ff;
         rsp_given_ff    <= pend_given_ff;
         rsp_wait_ff     <= pend_wait_ff;
         rsp_wake_ff     <= pend_wake_ff;
         rsp_wake_req_ff <= pend_wake_ff ? waiter_rd_ff : '0;
      end
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_slot_given     = rsp_given_ff;
   assign rsp_must_wait      = rsp_wait_ff;
   assign rsp_wake_valid     = rsp_wake_ff;
   assign rsp_wake_requester = rsp_wake_req_ff;

endmodule

`default_nettype wire

[sv/semaphore_table_with_wait_queues_unit.sv]
// semaphore table with per-slot fifo wait queues: top level
//
// one request per input transfer on req_*: kind (create, down, up, close),
// slot, initial_count and requester; every request gives exactly one
// result transfer on rsp_*: status, slot_given, must_wait, wake_valid and
// wake_requester. a transfer happens when valid is high and stall is low.
// the request is registered at the input transfer, executed into a pending
// result and loaded into the output register; a new request is taken in
// the finish state but never during execute. the rate is set by the
// read-modify-write of the slot entry (count, queue head, queue fill)
// in the single-port slot table: read at capture, written the cycle after.
// a result waiting in the output register does not block the next request;
// if the receiver stalls, the finished result of that next request waits
// in the datapath and req_stall stays high until the output register frees.
// reset clears the in-use flags and all control state; the slot table and
// waiter store need no clearing, since a slot entry is written by create
// before it is read and a waiter entry is read only after it was queued.
`default_nettype none

module semaphore_table_with_wait_queues_unit #(
   parameter int NUM_SLOTS   = 16,
   parameter int QUEUE_DEPTH = 8
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // request channel
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic [1:0]                              req_kind,
   input  wire logic [swq_pkg::SLOT_BITS-1:0]           req_slot,
   input  wire logic signed [swq_pkg::COUNT_BITS-1:0]   req_initial_count,
   input  wire logic [swq_pkg::REQUESTER_BITS-1:0]      req_requester,
   // result channel
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic [swq_pkg::STATUS_BITS-1:0]              rsp_status,
   output logic [swq_pkg::SLOT_BITS-1:0]                rsp_slot_given,
   output logic                                         rsp_must_wait,
   output logic                                         rsp_wake_valid,
   output logic [swq_pkg::REQUESTER_BITS-1:0]           rsp_wake_requester
);

   swq_pkg::cmd_type cmd;

   // sequencing: capture, execute, load result
   swq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // slot table, wait queues and result registers
   swq_datapath #(
      .NUM_SLOTS   (NUM_SLOTS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_kind           (req_kind),
      .req_slot           (req_slot),
      .req_initial_count  (req_initial_count),
      .req_requester      (req_requester),
      .rsp_status         (rsp_status),
      .rsp_slot_given     (rsp_slot_given),
      .rsp_must_wait      (rsp_must_wait),
      .rsp_wake_valid     (rsp_wake_valid),
      .rsp_wake_requester (rsp_wake_requester)
   );

`ifndef NO_ASSERTIONS
   // every captured request is executed in the next cycle
   a_capture_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.exec)
      else $error("captured request not executed");

   // one execute cycle per request
   a_single_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> !cmd.exec)
      else $error("execute held for two cycles");

   // no new request is taken while one is executing
   a_no_capture_in_exec: assert property (@(posedge clock) disable iff (reset)
      !(cmd.capture && cmd.exec))
      else $error("capture during execute");

   // a result is loaded only into a free output register
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid || !rsp_stall))
      else $error("result overwrote a pending transfer");

   // a request never both queues and releases a waiter
   a_wait_xor_wake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_must_wait && rsp_wake_valid))
      else $error("must_wait and wake_valid both set");
`endif

endmodule

`default_nettype wire

[sim/tb_top.sv]
// testbench for the semaphore table with per-slot fifo wait queues
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS      = 16;
   localparam int QUEUE_DEPTH    = 8;
   localparam int REQUEST_TARGET = 450;  // stimulus stops once this many requests went in
   localparam int PHASE_LENGTH   = 60;   // requests per idling mix
   localparam int STUCK_LIMIT    = 4000; // cycles with no transfer on either side
   localparam int MAX_REPORTS    = 10;
   localparam int SETTLE_CYCLES  = 8;    // idle margin after the last result

   // one result transfer as seen on rsp_*
   typedef struct packed {
      logic [swq_pkg::STATUS_BITS-1:0]    status;
      logic [swq_pkg::SLOT_BITS-1:0]      slot_given;
      logic                               must_wait;
      logic                               wake_valid;
      logic [swq_pkg::REQUESTER_BITS-1:0] wake_requester;
   } outcome_type;

   // shadow of the semaphore table plus the queue of results still to come
   class semaphore_scoreboard;
      bit                                    in_use [NUM_SLOTS];
      logic signed [swq_pkg::COUNT_BITS-1:0] count [NUM_SLOTS];
      logic [swq_pkg::REQUESTER_BITS-1:0]    waiters [NUM_SLOTS][QUEUE_DEPTH];
      int unsigned                           head [NUM_SLOTS];
      int unsigned                           fill [NUM_SLOTS];
      logic [swq_pkg::SLOT_BITS-1:0]         last_created;
      outcome_type                           expected_q [$];
      int unsigned                           mismatches;
      int unsigned                           requests;
      int unsigned                           waits;
      int unsigned                           wakes;
      int unsigned                           by_status [8];

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function int unsigned live_slots();
         int unsigned n;
         n = 0;
         for (int s = 0; s < NUM_SLOTS; s++)
            if (in_use[s]) n++;
         return n;
      endfunction

      // an input transfer happened: update the shadow table, queue the result it must give
      function void note_request(swq_pkg::kind_type kind,
                                 logic [swq_pkg::SLOT_BITS-1:0] slot,
                                 logic signed [swq_pkg::COUNT_BITS-1:0] init_count,
                                 logic [swq_pkg::REQUESTER_BITS-1:0] who);
         outcome_type r;
         int unsigned pos;
         int          s;
         r.status         = swq_pkg::STATUS_OK;
         r.slot_given     = slot;
         r.must_wait      = 1'b0;
         r.wake_valid     = 1'b0;
         r.wake_requester = '0;
         if (kind == swq_pkg::KIND_CREATE) begin
            // lowest free slot wins, fresh count and an empty queue
            r.slot_given = '0;
            r.status     = swq_pkg::STATUS_TABLE_FULL;
            for (s = 0; s < NUM_SLOTS; s++) begin
               if (!in_use[s]) begin
                  in_use[s]    = 1'b1;
                  count[s]     = init_count;
                  head[s]      = 0;
                  fill[s]      = 0;
                  r.slot_given = s[swq_pkg::SLOT_BITS-1:0];
                  r.status     = swq_pkg::STATUS_OK;
                  last_created = s[swq_pkg::SLOT_BITS-1:0];
                  break;
               end
            end
         end else if (!in_use[slot]) begin
            r.status = swq_pkg::STATUS_INVALID;
         end else if (kind == swq_pkg::KIND_DOWN) begin
            if (count[slot] == swq_pkg::COUNT_MIN) begin
               // count floor, refused like a full queue
               r.status = swq_pkg::STATUS_QUEUE_FULL;
            end else if (count[slot] <= 0) begin
               if (fill[slot] >= QUEUE_DEPTH) begin
                  r.status = swq_pkg::STATUS_QUEUE_FULL;
               end else begin
                  pos = (head[slot] + fill[slot]) % QUEUE_DEPTH;
                  waiters[slot][pos] = who;
                  fill[slot]++;
                  count[slot] = count[slot] - 16'sd1;
                  r.must_wait = 1'b1;
               end
            end else begin
               count[slot] = count[slot] - 16'sd1;
            end
         end else if (kind == swq_pkg::KIND_UP) begin
            // saturate at the ceiling, then release the queue head if still at or below zero
            if (count[slot] != swq_pkg::COUNT_MAX)
               count[slot] = count[slot] + 16'sd1;
            if (count[slot] <= 0 && fill[slot] > 0) begin
               r.wake_valid     = 1'b1;
               r.wake_requester = waiters[slot][head[slot]];
               head[slot]       = (head[slot] + 1) % QUEUE_DEPTH;
               fill[slot]--;
            end
         end else begin
            if (fill[slot] > 0)
               r.status = swq_pkg::STATUS_WAITERS;
            else
               in_use[slot] = 1'b0;
         end
         requests++;
         by_status[r.status]++;
         if (r.must_wait) waits++;
         if (r.wake_valid) wakes++;
         expected_q.push_back(r);
      endfunction

      // a result transfer happened: compare it with the oldest expectation
      function void check_result(outcome_type got);
         outcome_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result transfer with nothing expected: status %0d slot %0d",
                        $time, got.status, got.slot_given);
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status || got.slot_given !== want.slot_given ||
             got.must_wait !== want.must_wait || got.wake_valid !== want.wake_valid ||
             got.wake_requester !== want.wake_requester) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("%0t: result mismatch, expected status %0d slot %0d wait %0b wake %0b/%02h",
                        $time, want.status, want.slot_given, want.must_wait,
                        want.wake_valid, want.wake_requester);
               $display("%0t:                  got status %0d slot %0d wait %0b wake %0b/%02h",
                        $time, got.status, got.slot_given, got.must_wait,
                        got.wake_valid, got.wake_requester);
            end
         end
      endfunction
   endclass

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   // request side
   logic                                   req_valid         = 1'b0;
   logic                                   req_stall;
   logic [1:0]                             req_kind          = swq_pkg::KIND_CREATE;
   logic [swq_pkg::SLOT_BITS-1:0]          req_slot          = '0;
   logic signed [swq_pkg::COUNT_BITS-1:0]  req_initial_count = '0;
   logic [swq_pkg::REQUESTER_BITS-1:0]     req_requester     = '0;

   // result side
   logic                                   rsp_valid;
   logic                                   rsp_stall         = 1'b0;
   logic [swq_pkg::STATUS_BITS-1:0]        rsp_status;
   logic [swq_pkg::SLOT_BITS-1:0]          rsp_slot_given;
   logic                                   rsp_must_wait;
   logic                                   rsp_wake_valid;
   logic [swq_pkg::REQUESTER_BITS-1:0]     rsp_wake_requester;

   semaphore_scoreboard sb;
   int unsigned         sender_idle_pct    = 0;
   int unsigned         receiver_stall_pct = 0;
   int unsigned         stuck_cycles       = 0;

   semaphore_table_with_wait_queues_unit #(
      .NUM_SLOTS   (NUM_SLOTS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_slot           (req_slot),
      .req_initial_count  (req_initial_count),
      .req_requester      (req_requester),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_slot_given     (rsp_slot_given),
      .rsp_must_wait      (rsp_must_wait),
      .rsp_wake_valid     (rsp_wake_valid),
      .rsp_wake_requester (rsp_wake_requester)
   );

   // receiver: check every result transfer, then pick the stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_result(outcome_type'{status: rsp_status, slot_given: rsp_slot_given,
                                       must_wait: rsp_must_wait,
                                       wake_valid: rsp_wake_valid,
                                       wake_requester: rsp_wake_requester});
      rsp_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
   end

   // watchdog: cycles in a row with no transfer on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
   end

   initial begin
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("timeout: no transfer for %0d cycles", STUCK_LIMIT);
      $display("tb_top failed");
      $finish;
   end

   // one request: optional idle gap, then hold the payload until the transfer
   task automatic send(swq_pkg::kind_type kind, logic [swq_pkg::SLOT_BITS-1:0] slot,
                       logic signed [swq_pkg::COUNT_BITS-1:0] init_count,
                       logic [swq_pkg::REQUESTER_BITS-1:0] who);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= kind;
      req_slot          <= slot;
      req_initial_count <= init_count;
      req_requester     <= who;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(kind, slot, init_count, who);
   endtask

   // sender holds off until every result is back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic set_idling(int unsigned mix);
      case (mix)
         0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         1:       begin sender_idle_pct = 84; receiver_stall_pct = 0;  end
         2:       begin sender_idle_pct = 0;  receiver_stall_pct = 84; end
         default: begin sender_idle_pct = 22; receiver_stall_pct = 22; end
      endcase
   endtask

   function automatic logic [swq_pkg::SLOT_BITS-1:0] random_slot();
      int unsigned v;
      v = $urandom_range(NUM_SLOTS - 1);
      return v[swq_pkg::SLOT_BITS-1:0];
   endfunction

   function automatic logic [swq_pkg::REQUESTER_BITS-1:0] random_who();
      int unsigned v;
      v = $urandom_range(255);
      return v[swq_pkg::REQUESTER_BITS-1:0];
   endfunction

   // any 16-bit pattern
   function automatic logic signed [swq_pkg::COUNT_BITS-1:0] any_count();
      int unsigned v;
      v = $urandom;
      return v[swq_pkg::COUNT_BITS-1:0];
   endfunction

   // mostly counts near zero so downs queue and ups wake, sometimes wide or extreme
   function automatic logic signed [swq_pkg::COUNT_BITS-1:0] random_count();
      int v;
      case ($urandom_range(9))
         0, 1:    v = $urandom;
         2:       v = $urandom_range(1) ? 32767 : -32768;
         default: v = int'($urandom_range(6)) - 3;
      endcase
      return v[swq_pkg::COUNT_BITS-1:0];
   endfunction

   // a slot that is in use, or any slot when the table is empty
   function automatic logic [swq_pkg::SLOT_BITS-1:0] pick_live_slot();
      logic [swq_pkg::SLOT_BITS-1:0] choices [$];
      for (int s = 0; s < NUM_SLOTS; s++)
         if (sb.in_use[s]) choices.push_back(s[swq_pkg::SLOT_BITS-1:0]);
      if (choices.size() == 0)
         return random_slot();
      return choices[$urandom_range(choices.size() - 1)];
   endfunction

   // drain a slot's waiters with ups, then close it
   task automatic retire_slot();
      logic [swq_pkg::SLOT_BITS-1:0] s;
      s = pick_live_slot();
      while (sb.in_use[s] && sb.fill[s] != 0)
         send(swq_pkg::KIND_UP, s, random_count(), random_who());
      send(swq_pkg::KIND_CLOSE, s, random_count(), random_who());
   endtask

   // one random episode; most are well-formed sequences on live slots
   task automatic random_episode();
      int unsigned                           roll;
      int unsigned                           downs;
      int unsigned                           ups;
      logic [swq_pkg::SLOT_BITS-1:0]         s;
      logic signed [swq_pkg::COUNT_BITS-1:0] limit_count;
      roll = $urandom_range(99);
      if (roll < 45) begin
         // single request, create favored while the table is sparse
         roll = $urandom_range(99);
         if (roll < (sb.live_slots() < 6 ? 40 : 10))
            send(swq_pkg::KIND_CREATE, random_slot(), random_count(), random_who());
         else if (roll < 55)
            send(swq_pkg::KIND_DOWN, pick_live_slot(), random_count(), random_who());
         else if (roll < 85)
            send(swq_pkg::KIND_UP, pick_live_slot(), random_count(), random_who());
         else
            send(swq_pkg::KIND_CLOSE, pick_live_slot(), random_count(), random_who());
      end else if (roll < 62) begin
         // burst of downs on one slot, at times long enough to overflow its queue, then ups
         if (sb.live_slots() == 0)
            send(swq_pkg::KIND_CREATE, random_slot(), '0, random_who());
         s     = pick_live_slot();
         downs = $urandom_range(1, 11);
         ups   = $urandom_range(downs + 1);
         repeat (downs) send(swq_pkg::KIND_DOWN, s, random_count(), random_who());
         repeat (ups) send(swq_pkg::KIND_UP, s, random_count(), random_who());
      end else if (roll < 72) begin
         retire_slot();
      end else if (roll < 77) begin
         // fill the table, one create too many, then free a few slots
         while (sb.live_slots() < NUM_SLOTS)
            send(swq_pkg::KIND_CREATE, random_slot(), random_count(), random_who());
         send(swq_pkg::KIND_CREATE, random_slot(), random_count(), random_who());
         repeat ($urandom_range(2, 6)) retire_slot();
      end else if (roll < 85) begin
         // count at or next to floor and ceiling
         case ($urandom_range(3))
            0:       limit_count = swq_pkg::COUNT_MIN;
            1:       limit_count = swq_pkg::COUNT_MIN + 16'sd1;
            2:       limit_count = swq_pkg::COUNT_MAX;
            default: limit_count = swq_pkg::COUNT_MAX - 16'sd1;
         endcase
         if (sb.live_slots() == NUM_SLOTS)
            retire_slot();
         send(swq_pkg::KIND_CREATE, random_slot(), limit_count, random_who());
         s = sb.last_created;
         if (limit_count < 0)
            repeat ($urandom_range(1, 3))
               send(swq_pkg::KIND_DOWN, s, random_count(), random_who());
         else
            repeat ($urandom_range(1, 3))
               send(swq_pkg::KIND_UP, s, random_count(), random_who());
      end else begin
         // noise: any kind, any slot, any payload
         send(swq_pkg::kind_type'($urandom_range(3)), random_slot(), any_count(),
              random_who());
      end
   endtask

   initial begin
      int unsigned mix;
      int unsigned next_switch;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: invalid slots on an empty table
      send(swq_pkg::KIND_UP, 4'h0, 16'sd0, 8'h00);
      send(swq_pkg::KIND_DOWN, 4'hf, -16'sd1, 8'hff);
      send(swq_pkg::KIND_CLOSE, 4'ha, 16'sd0, 8'h5a);
      // creates land in slots 0..3, including both count extremes
      send(swq_pkg::KIND_CREATE, 4'hf, 16'sd0, 8'h00);
      send(swq_pkg::KIND_CREATE, 4'h0, swq_pkg::COUNT_MAX, 8'hff);
      send(swq_pkg::KIND_CREATE, 4'h0, swq_pkg::COUNT_MIN, 8'h00);
      send(swq_pkg::KIND_CREATE, 4'h0, 16'sd1, 8'h00);
      // ceiling holds, floor is refused
      send(swq_pkg::KIND_UP, 4'h1, 16'sd0, 8'h00);
      send(swq_pkg::KIND_DOWN, 4'h2, 16'sd0, 8'h00);
      // slot 3: reach zero, queue two waiters, close refused, wake both in order
      send(swq_pkg::KIND_DOWN, 4'h3, 16'sd0, 8'h01);
      send(swq_pkg::KIND_DOWN, 4'h3, 16'sd0, 8'haa);
      send(swq_pkg::KIND_DOWN, 4'h3, 16'sd0, 8'h55);
      send(swq_pkg::KIND_CLOSE, 4'h3, 16'sd0, 8'h00);
      send(swq_pkg::KIND_UP, 4'h3, 16'sd0, 8'h00);
      send(swq_pkg::KIND_UP, 4'h3, 16'sd0, 8'h00);
      send(swq_pkg::KIND_UP, 4'h3, 16'sd0, 8'h00);
      // negative count with an empty queue gives no wake
      send(swq_pkg::KIND_CREATE, 4'h0, -16'sd2, 8'h00);
      send(swq_pkg::KIND_UP, 4'h4, 16'sd0, 8'h00);
      send(swq_pkg::KIND_CLOSE, 4'h3, 16'sd0, 8'h00);
      send(swq_pkg::KIND_CLOSE, 4'h4, 16'sd0, 8'h00);
      send(swq_pkg::KIND_DOWN, 4'h3, 16'sd0, 8'h00);
      drain();

      // random part, rotating through the idling mixes with a full drain between them
      mix         = 0;
      next_switch = sb.requests + PHASE_LENGTH;
      set_idling(mix);
      while (sb.requests < REQUEST_TARGET) begin
         if (sb.requests >= next_switch) begin
            drain();
            mix         = (mix + 1) % 4;
            next_switch = sb.requests + PHASE_LENGTH;
            set_idling(mix);
         end
         random_episode();
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d requests over four idling mixes: %0d queued waits, %0d wakes",
               sb.requests, sb.waits, sb.wakes);
      $display("status counts ok/invalid/queue full/table full/waiters: %0d/%0d/%0d/%0d/%0d",
               sb.by_status[swq_pkg::STATUS_OK], sb.by_status[swq_pkg::STATUS_INVALID],
               sb.by_status[swq_pkg::STATUS_QUEUE_FULL],
               sb.by_status[swq_pkg::STATUS_TABLE_FULL],
               sb.by_status[swq_pkg::STATUS_WAITERS]);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

[sim.f]
sv/swq_pkg.sv
sv/swq_ctrl.sv
sv/swq_datapath.sv
sv/semaphore_table_with_wait_queues_unit.sv
sim/tb_top.sv
